>>> hdl/lbmt_pkg.sv
// ----------------------------------------------------------------------------
// lbmt_pkg
// Types and constants for the learning bridge MAC table.
// ----------------------------------------------------------------------------
`default_nettype none

package lbmt_pkg;

    localparam int unsigned MAC_W     = 48;
    localparam int unsigned PORT_W    = 4;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned COUNT_W   = 9;

    localparam logic [LEN_W-1:0]  MIN_FRAME_LEN = 16'd14;
    localparam logic [MAC_W-1:0]  MAC_BCAST     = {6{8'hFF}};
    localparam logic [TIME_W-1:0] AGING_RESET   = 32'd300;

    typedef enum logic [1:0] {
        OP_FWD    = 2'd0,
        OP_STATIC = 2'd1,
        OP_AGE    = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_FORWARD = 2'd0,
        ACT_FLOOD   = 2'd1,
        ACT_DROP    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } eng_state_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [MAC_W-1:0]  dst_mac;
        logic [MAC_W-1:0]  src_mac;
        logic [PORT_W-1:0] port;
        logic [LEN_W-1:0]  frame_len;
        logic [TIME_W-1:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [PORT_W-1:0]  egress_port;
        logic               status;
        logic [COUNT_W-1:0] entry_count;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [MAC_W-1:0]  dst_mac;
        logic [MAC_W-1:0]  src_mac;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] now_time;
        logic              short_frame;
    } cmd_t;

    typedef struct packed {
        logic              vld;
        logic              st;
        logic [TIME_W-1:0] tm;
        logic [PORT_W-1:0] prt;
        logic [MAC_W-1:0]  mac;
    } entry_t;

endpackage

`default_nettype wire

>>> hdl/lbmt_front.sv
// ----------------------------------------------------------------------------
// lbmt_front
// Input side: takes items, classifies short frames, two-deep command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lbmt_front
    import lbmt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          q_valid,
    output cmd_t          q_cmd,
    input  wire logic     q_pop
);

    cmd_t       q_mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    cmd_t       cmd;

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_cmd    = q_mem_reg[rp_reg];

    always_comb
    begin
        cmd.op          = in_data.op;
        cmd.dst_mac     = in_data.dst_mac;
        cmd.src_mac     = in_data.src_mac;
        cmd.port        = in_data.port;
        cmd.now_time    = in_data.now_time;
        cmd.short_frame = (in_data.frame_len < MIN_FRAME_LEN);
    end

    always_comb
    begin
        wp_next   = wp_reg ^ push;
        rp_next   = rp_reg ^ q_pop;
        fill_next = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wp_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> fill_reg != 2'd0)
        else $error("pop from empty queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("queue overfilled");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd2 && !q_pop) |=> fill_reg == 2'd2)
        else $error("full queue lost an entry");

`default_nettype wire
endmodule

>>> hdl/lbmt_engine.sv
// ----------------------------------------------------------------------------
// lbmt_engine
// Back end: table memory, one-entry-per-cycle scan, commit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbmt_engine
    import lbmt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 256
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire cmd_t              q_cmd,
    output logic                   q_pop,
    input  wire logic              cfg_valid,
    input  wire logic [TIME_W-1:0] cfg_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [AW:0]   ISSUE_END = (AW+1)'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_ENTRIES - 1);

    entry_t mem [TABLE_ENTRIES];
    entry_t rdata_reg;

    eng_state_t        state_reg, state_next;
    logic [AW:0]       idx_reg, idx_next;
    logic              rv_reg, rv_next;
    logic [AW-1:0]     ri_reg, ri_next;
    cmd_t              cmd_reg, cmd_next;
    logic              src_hit_reg, src_hit_next;
    logic [AW-1:0]     src_idx_reg, src_idx_next;
    logic              src_st_reg, src_st_next;
    logic [TIME_W-1:0] src_tm_reg, src_tm_next;
    logic              free_hit_reg, free_hit_next;
    logic [AW-1:0]     free_idx_reg, free_idx_next;
    logic              dst_hit_reg, dst_hit_next;
    logic [PORT_W-1:0] dst_prt_reg, dst_prt_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [TIME_W-1:0] aging_reg, aging_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    entry_t            wdata;
    logic [TIME_W-1:0] age_diff;
    logic              remove;
    logic [1:0]        act;
    logic [PORT_W-1:0] egr;
    logic              stat;
    logic [CW-1:0]     cnt_after;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign age_diff  = cmd_reg.now_time - rdata_reg.tm;
    assign remove    = rdata_reg.vld && !rdata_reg.st &&
                       ((cmd_reg.op == OP_FLUSH) ||
                        (cmd_reg.op == OP_AGE && age_diff > aging_reg));

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rv_next        = rv_reg;
        ri_next        = ri_reg;
        cmd_next       = cmd_reg;
        src_hit_next   = src_hit_reg;
        src_idx_next   = src_idx_reg;
        src_st_next    = src_st_reg;
        src_tm_next    = src_tm_reg;
        free_hit_next  = free_hit_reg;
        free_idx_next  = free_idx_reg;
        dst_hit_next   = dst_hit_reg;
        dst_prt_next   = dst_prt_reg;
        cnt_next       = cnt_reg;
        aging_next     = cfg_valid ? cfg_data : aging_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        re             = 1'b0;
        waddr          = '0;
        raddr          = idx_reg[AW-1:0];
        wdata          = '0;
        act            = ACT_FORWARD;
        egr            = '0;
        stat           = 1'b0;
        cnt_after      = cnt_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = idx_reg[AW-1:0];
                idx_next = idx_reg + 1'b1;
                if (idx_reg[AW-1:0] == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    cmd_next      = q_cmd;
                    idx_next      = '0;
                    rv_next       = 1'b0;
                    src_hit_next  = 1'b0;
                    free_hit_next = 1'b0;
                    dst_hit_next  = 1'b0;
                    if (q_cmd.op == OP_FWD && q_cmd.short_frame)
                        state_next = ST_COMMIT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rv_next = 1'b0;
                if (idx_reg < ISSUE_END)
                begin
                    re       = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                    ri_next  = idx_reg[AW-1:0];
                end
                if (rv_reg)
                begin
                    if (rdata_reg.vld && rdata_reg.mac == cmd_reg.src_mac && !src_hit_reg)
                    begin
                        src_hit_next = 1'b1;
                        src_idx_next = ri_reg;
                        src_st_next  = rdata_reg.st;
                        src_tm_next  = rdata_reg.tm;
                    end
                    if (!rdata_reg.vld && !free_hit_reg)
                    begin
                        free_hit_next = 1'b1;
                        free_idx_next = ri_reg;
                    end
                    if (rdata_reg.vld && rdata_reg.mac == cmd_reg.dst_mac && !dst_hit_reg)
                    begin
                        dst_hit_next = 1'b1;
                        dst_prt_next = rdata_reg.prt;
                    end
                    if (remove)
                    begin
                        we        = 1'b1;
                        waddr     = ri_reg;
                        wdata     = rdata_reg;
                        wdata.vld = 1'b0;
                        cnt_next  = cnt_reg - 1'b1;
                    end
                    if (ri_reg == LAST_IDX)
                        state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (cmd_reg.op == OP_FWD)
                    begin
                        if (cmd_reg.short_frame)
                        begin
                            act = ACT_DROP;
                        end
                        else
                        begin
                            if (src_hit_reg)
                            begin
                                we    = 1'b1;
                                waddr = src_idx_reg;
                                wdata = '{vld: 1'b1, st: src_st_reg, tm: cmd_reg.now_time,
                                          prt: cmd_reg.port, mac: cmd_reg.src_mac};
                            end
                            else if (free_hit_reg)
                            begin
                                we        = 1'b1;
                                waddr     = free_idx_reg;
                                wdata     = '{vld: 1'b1, st: 1'b0, tm: cmd_reg.now_time,
                                              prt: cmd_reg.port, mac: cmd_reg.src_mac};
                                cnt_after = cnt_reg + 1'b1;
                            end
                            if (cmd_reg.dst_mac == MAC_BCAST)
                                act = ACT_FLOOD;
                            else if (cmd_reg.dst_mac == cmd_reg.src_mac &&
                                     (src_hit_reg || free_hit_reg))
                                act = ACT_DROP;
                            else if (!dst_hit_reg)
                                act = ACT_FLOOD;
                            else if (dst_prt_reg == cmd_reg.port)
                                act = ACT_DROP;
                            else
                            begin
                                act = ACT_FORWARD;
                                egr = dst_prt_reg;
                            end
                        end
                    end
                    else if (cmd_reg.op == OP_STATIC)
                    begin
                        if (src_hit_reg)
                        begin
                            we    = 1'b1;
                            waddr = src_idx_reg;
                            wdata = '{vld: 1'b1, st: 1'b1, tm: src_tm_reg,
                                      prt: cmd_reg.port, mac: cmd_reg.src_mac};
                        end
                        else if (free_hit_reg)
                        begin
                            we        = 1'b1;
                            waddr     = free_idx_reg;
                            wdata     = '{vld: 1'b1, st: 1'b1, tm: cmd_reg.now_time,
                                          prt: cmd_reg.port, mac: cmd_reg.src_mac};
                            cnt_after = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            stat = 1'b1;
                        end
                    end
                    cnt_next                    = cnt_after;
                    out_valid_next              = 1'b1;
                    out_data_next.action        = act;
                    out_data_next.egress_port   = egr;
                    out_data_next.status        = stat;
                    out_data_next.entry_count   = COUNT_W'(cnt_after);
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        ri_reg        <= ri_next;
        src_idx_reg   <= src_idx_next;
        src_st_reg    <= src_st_next;
        src_tm_reg    <= src_tm_next;
        free_idx_reg  <= free_idx_next;
        dst_prt_reg   <= dst_prt_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            rv_reg        <= 1'b0;
            src_hit_reg   <= 1'b0;
            free_hit_reg  <= 1'b0;
            dst_hit_reg   <= 1'b0;
            cnt_reg       <= '0;
            aging_reg     <= AGING_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rv_reg        <= rv_next;
            src_hit_reg   <= src_hit_next;
            free_hit_reg  <= free_hit_next;
            dst_hit_reg   <= dst_hit_next;
            cnt_reg       <= cnt_next;
            aging_reg     <= aging_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("command taken outside idle");

    a_result_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_COMMIT))
        else $error("result without commit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_data_reg))
        else $error("pending result overwritten");

`default_nettype wire
endmodule

>>> hdl/learning_bridge_mac_table_top.sv
// ----------------------------------------------------------------------------
// learning_bridge_mac_table_top
// Learning bridge MAC table: learn, lookup, static add, age and flush.
//
//   channel | ports                        | payload
//   --------+------------------------------+-------------------
//   in      | in_valid / in_ready          | in_data (in_item_t)
//   out     | out_valid / out_ready        | out_data (out_item_t)
//   cfg     | cfg_valid / cfg_ready        | cfg_data (age limit)
//
// A frame shorter than 14 bytes skips the scan; every other item scans the table
// memory one entry per cycle. After reset a clearing pass over all TABLE_ENTRIES
// entries runs before the first item is processed; up to two input transfers
// queue meanwhile.
// A stalled result is held in the output register while the next item scans.
// ----------------------------------------------------------------------------
`default_nettype none

module learning_bridge_mac_table_top
    import lbmt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 256
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [TIME_W-1:0] cfg_data
);

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    assign cfg_ready = 1'b1;

    lbmt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    lbmt_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`default_nettype wire
endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the learning bridge MAC table. A directed table
// covers short frames, broadcast, learning, moves, static adds, aging with
// wrap and flush. Random phases then run under several aging times,
// including a fill phase that overflows the table. Every result is checked
// against a typed expected value or an in-bench forwarding database model,
// with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import lbmt_pkg::*;

    localparam int DEPTH      = 256;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t result;
    } vector_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [TIME_W-1:0] cfg_data;

    learning_bridge_mac_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // forwarding database model
    bit                fdb_valid [DEPTH];
    bit                fdb_static[DEPTH];
    logic [MAC_W-1:0]  fdb_mac   [DEPTH];
    logic [PORT_W-1:0] fdb_port  [DEPTH];
    logic [TIME_W-1:0] fdb_time  [DEPTH];
    logic [TIME_W-1:0] age_limit;

    out_item_t         pending_results[$];
    int                errors;
    int                idle_cycles;
    int                burst_left;
    int                rx_mode;
    int                rx_cycle;
    logic [MAC_W-1:0]  mac_pool[24];
    logic [TIME_W-1:0] clock_now;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int find_mac(logic [MAC_W-1:0] mac);
        for (int i = 0; i < DEPTH; i++)
            if (fdb_valid[i] && fdb_mac[i] == mac)
                return i;
        return -1;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < DEPTH; i++)
            if (!fdb_valid[i])
                return i;
        return -1;
    endfunction

    function automatic out_item_t fdb_apply(in_item_t it);
        out_item_t r;
        int        s;
        int        n;
        r = '0;
        n = 0;
        case (op_t'(it.op))
            OP_FWD:
            begin
                if (it.frame_len < MIN_FRAME_LEN)
                    r.action = ACT_DROP;
                else
                begin
                    s = find_mac(it.src_mac);
                    if (s >= 0)
                    begin
                        fdb_port[s] = it.port;
                        fdb_time[s] = it.now_time;
                    end
                    else
                    begin
                        s = find_free();
                        if (s >= 0)
                        begin
                            fdb_valid[s]  = 1'b1;
                            fdb_static[s] = 1'b0;
                            fdb_mac[s]    = it.src_mac;
                            fdb_port[s]   = it.port;
                            fdb_time[s]   = it.now_time;
                        end
                    end
                    s = (it.dst_mac == MAC_BCAST) ? -1 : find_mac(it.dst_mac);
                    if (s < 0)
                        r.action = ACT_FLOOD;
                    else if (fdb_port[s] == it.port)
                        r.action = ACT_DROP;
                    else
                    begin
                        r.action      = ACT_FORWARD;
                        r.egress_port = fdb_port[s];
                    end
                end
            end
            OP_STATIC:
            begin
                s = find_mac(it.src_mac);
                if (s >= 0)
                begin
                    fdb_port[s]   = it.port;
                    fdb_static[s] = 1'b1;
                end
                else
                begin
                    s = find_free();
                    if (s >= 0)
                    begin
                        fdb_valid[s]  = 1'b1;
                        fdb_static[s] = 1'b1;
                        fdb_mac[s]    = it.src_mac;
                        fdb_port[s]   = it.port;
                        fdb_time[s]   = it.now_time;
                    end
                    else
                        r.status = 1'b1;
                end
            end
            OP_AGE:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (fdb_valid[i] && !fdb_static[i] &&
                        (it.now_time - fdb_time[i]) > age_limit)
                        fdb_valid[i] = 1'b0;
            end
            default:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (!fdb_static[i])
                        fdb_valid[i] = 1'b0;
            end
        endcase
        for (int i = 0; i < DEPTH; i++)
            n += fdb_valid[i];
        r.entry_count = n[COUNT_W-1:0];
        return r;
    endfunction

    function automatic in_item_t mk(op_t op, logic [MAC_W-1:0] dst, logic [MAC_W-1:0] src,
                                    logic [PORT_W-1:0] prt, logic [LEN_W-1:0] len,
                                    logic [TIME_W-1:0] now);
        in_item_t it;
        it.op        = op;
        it.dst_mac   = dst;
        it.src_mac   = src;
        it.port      = prt;
        it.frame_len = len;
        it.now_time  = now;
        return it;
    endfunction

    function automatic out_item_t res(action_t act, int egr, int cnt);
        out_item_t r;
        r.action      = act;
        r.egress_port = egr[PORT_W-1:0];
        r.status      = 1'b0;
        r.entry_count = cnt[COUNT_W-1:0];
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // one input transfer, with burst/gap pacing
    task automatic send(in_item_t it, bit typed, out_item_t typed_res);
        out_item_t r;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        r = fdb_apply(it);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_aging(logic [TIME_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        age_limit = v;
        @(posedge clk);
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
    endfunction

    function automatic in_item_t rand_item(bit fwd_only, bit fresh);
        in_item_t    it;
        int          pick;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            clock_now = $urandom();
        else
            clock_now = clock_now + $urandom_range(0, 200);
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 13))
                                          : 16'($urandom_range(14, 65535));
        if ($urandom_range(0, 19) == 0)
            len = 16'($urandom_range(0, 65535));
        it = mk(OP_FWD, mac_pool[$urandom_range(0, 23)],
                fresh ? rand_mac() : mac_pool[$urandom_range(0, 23)],
                4'($urandom_range(0, 15)), len, clock_now);
        if ($urandom_range(0, 19) == 0)
            it.dst_mac = MAC_BCAST;
        else if ($urandom_range(0, 9) == 0)
            it.dst_mac = rand_mac();
        if (!fwd_only)
        begin
            if (pick >= 92)
                it.op = OP_FLUSH;
            else if (pick >= 80)
                it.op = OP_AGE;
            else if (pick >= 70)
                it.op = OP_STATIC;
        end
        return it;
    endfunction

    task automatic random_phase(int count, bit fwd_only, bit fresh);
        for (int i = 0; i < count; i++)
            send(rand_item(fwd_only, fresh), 1'b0, '0);
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 300 == 0)
            rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result %0h at %0t", out_data, $realtime);
                errors++;
            end
            else
            begin
                out_item_t want;
                want = pending_results.pop_front();
                if (out_data.action !== want.action)
                    report("action", out_data.action, want.action);
                if (out_data.egress_port !== want.egress_port)
                    report("egress_port", out_data.egress_port, want.egress_port);
                if (out_data.status !== want.status)
                    report("status", out_data.status, want.status);
                if (out_data.entry_count !== want.entry_count)
                    report("entry_count", out_data.entry_count, want.entry_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        vector_t          vectors[$];
        logic [MAC_W-1:0] ma;
        logic [MAC_W-1:0] mb;
        logic [MAC_W-1:0] mc;
        logic [MAC_W-1:0] md;
        logic [MAC_W-1:0] me;

        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        errors      = 0;
        idle_cycles = 0;
        burst_left  = 0;
        rx_mode     = 0;
        rx_cycle    = 0;
        clock_now   = 0;
        age_limit   = AGING_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            fdb_valid[i]  = 1'b0;
            fdb_static[i] = 1'b0;
        end
        foreach (mac_pool[i])
            mac_pool[i] = rand_mac();
        ma = 48'h0011_2233_4455;
        mb = 48'hAABB_CCDD_EEFF;
        mc = 48'h0200_0000_0001;
        md = 48'h5A5A_A5A5_5A5A;
        me = 48'hFFFF_FFFF_FFFE;

        vectors = '{
            '{mk(OP_FLUSH, '0, '0, 0, 0, 0), 1, res(ACT_FORWARD, 0, 0)},
            '{mk(OP_AGE, '0, '0, 0, 0, 0), 1, res(ACT_FORWARD, 0, 0)},
            '{mk(OP_FWD, mb, ma, 0, 0, 0), 1, res(ACT_DROP, 0, 0)},
            '{mk(OP_FWD, mb, ma, 0, 13, 0), 1, res(ACT_DROP, 0, 0)},
            '{mk(OP_FWD, MAC_BCAST, ma, 0, 14, 100), 1, res(ACT_FLOOD, 0, 1)},
            '{mk(OP_FWD, ma, mb, 15, 16'hFFFF, 110), 0, '0},
            '{mk(OP_FWD, mb, ma, 15, 64, 120), 0, '0},
            '{mk(OP_FWD, ma, mb, 3, 64, 130), 0, '0},
            '{mk(OP_STATIC, '0, mc, 7, 0, 0), 0, '0},
            '{mk(OP_STATIC, '0, ma, 9, 0, 140), 0, '0},
            '{mk(OP_FWD, mc, '0, 7, 60, 150), 0, '0},
            '{mk(OP_FWD, '0, MAC_BCAST, 2, 60, 160), 0, '0},
            '{mk(OP_AGE, '0, '0, 0, 0, 32'hFFFF_FFFF), 0, '0},
            '{mk(OP_FWD, ma, md, 9, 100, 1000), 0, '0},
            '{mk(OP_AGE, '0, '0, 0, 0, 1300), 0, '0},
            '{mk(OP_AGE, '0, '0, 0, 0, 1301), 0, '0},
            '{mk(OP_FWD, me, me, 12, 1500, 32'hFFFF_FF00), 0, '0},
            '{mk(OP_AGE, '0, '0, 0, 0, 32'h0000_002B), 0, '0},
            '{mk(OP_AGE, '0, '0, 0, 0, 32'h0000_002C), 0, '0},
            '{mk(OP_FWD, mc, ma, 4, 100, 200), 0, '0},
            '{mk(OP_FLUSH, MAC_BCAST, MAC_BCAST, 15, 16'hFFFF, 32'hFFFF_FFFF), 0, '0},
            '{mk(OP_STATIC, '0, MAC_BCAST, 15, 0, 0), 0, '0},
            '{mk(OP_FWD, MAC_BCAST, md, 1, 14, 5), 0, '0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (vectors[i])
            send(vectors[i].item, vectors[i].typed, vectors[i].result);
        drain();

        write_aging('0);
        random_phase(100, 0, 0);
        drain();

        write_aging(32'hFFFF_FFFF);
        random_phase(50, 0, 0);
        drain();

        // fill the table past capacity
        write_aging($urandom());
        send(mk(OP_FLUSH, '0, '0, 0, 0, 0), 0, '0);
        random_phase(270, 1, 1);
        for (int i = 0; i < 6; i++)
            send(mk(OP_STATIC, '0, rand_mac(), 4'($urandom_range(0, 15)), 64, $urandom()),
                 0, '0);
        random_phase(10, 0, 0);
        drain();

        write_aging($urandom_range(50, 400));
        send(mk(OP_FLUSH, '0, '0, 0, 0, 0), 0, '0);
        random_phase(40, 0, 0);
        drain();
        random_phase(30, 0, 0);

        drain();
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
